// File: design/rcw_pkg.sv
// Shared types and constants for the rectangular cache line walker.
package rcw_pkg;

  localparam int LINE_BYTES_DEF    = 32;
  localparam int MAX_ROW_BYTES_DEF = 1024;
  localparam int MAX_LINES         = 33;
  localparam int CNT_W             = $clog2(MAX_LINES);
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        op;
    logic        first_row;
    logic [31:0] start_address;
    logic [10:0] row_bytes;
    logic [15:0] row_stride;
  } row_t;

  typedef struct packed {
    logic [31:0] line_address;
    logic        line_op;
    logic        row_done;
  } line_t;

  // One run of lines handed from the front to the back.
  typedef struct packed {
    logic [31:0]      start_address;
    logic [CNT_W-1:0] cnt_m1;
    logic             op;
  } span_t;

  typedef enum logic {
    FR_IDLE,
    FR_CLASSIFY
  } front_state_t;

endpackage

// File: design/rcw_front.sv
// Front: accepts rows, tracks row address and last line, queues line runs.
module rcw_front #(
  parameter int LINE_BYTES    = rcw_pkg::LINE_BYTES_DEF,
  parameter int MAX_ROW_BYTES = rcw_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          row_valid,
  output logic          row_stall,
  input  rcw_pkg::row_t row_data,
  input  logic          cache_enabled,
  output logic          push,
  output rcw_pkg::span_t push_data,
  input  logic          full
);
  import rcw_pkg::*;

  localparam int LB_BITS = $clog2(LINE_BYTES);
  localparam int IW      = 32 - LB_BITS;

  front_state_t state, state_next;

  logic [31:0]   row_address;
  logic [31:0]   row_address_next;
  logic [31:0]   addr;
  logic [10:0]   nbytes;
  logic          op_r;
  logic          first_r;
  logic          last_valid;
  logic [IW-1:0] last_line_index;

  logic [32:0]   end_addr;
  logic [IW-1:0] first_idx;
  logic [IW:0]   last_idx;
  logic          skip;
  logic [IW:0]   first_adj;
  logic [IW:0]   diff;
  logic          need;
  logic          accept;

  assign accept = row_valid && !row_stall;
  assign row_address_next = row_data.first_row ? row_data.start_address
                                               : row_address + {16'b0, row_data.row_stride};

  assign end_addr  = {1'b0, addr} + {22'b0, nbytes} - 33'd1;
  assign first_idx = addr[31:LB_BITS];
  assign last_idx  = end_addr[32:LB_BITS];
  assign skip      = last_valid && !first_r && (first_idx == last_line_index);
  assign first_adj = {1'b0, first_idx} + {{IW{1'b0}}, skip};
  assign diff      = last_idx - first_adj;
  assign need      = (nbytes != 11'd0) && cache_enabled && (first_adj <= last_idx);

  always_comb begin
    push_data.start_address = {first_adj[IW-1:0], {LB_BITS{1'b0}}};
    push_data.op            = op_r;
    if (diff >= (IW+1)'(MAX_LINES - 1)) begin
      push_data.cnt_m1 = CNT_W'(MAX_LINES - 1);
    end else begin
      push_data.cnt_m1 = diff[CNT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: begin
        if (row_valid) state_next = FR_CLASSIFY;
      end
      FR_CLASSIFY: begin
        // hold while the run has no room in the queue
        if (!(need && full)) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    row_stall = (state != FR_IDLE);
    push      = (state == FR_CLASSIFY) && need && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= FR_IDLE;
      row_address     <= '0;
      last_valid      <= 1'b0;
      last_line_index <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        row_address <= row_address_next;
      end
      if (state == FR_CLASSIFY && state_next == FR_IDLE) begin
        if (first_r) last_valid <= 1'b0;
        if (nbytes != 11'd0) begin
          last_valid      <= 1'b1;
          last_line_index <= last_idx[IW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr    <= row_address_next;
      op_r    <= row_data.op;
      first_r <= row_data.first_row;
      if (int'(row_data.row_bytes) > MAX_ROW_BYTES) begin
        nbytes <= 11'(MAX_ROW_BYTES);
      end else begin
        nbytes <= row_data.row_bytes;
      end
    end
  end

endmodule

// File: design/rcw_queue.sv
// Small run queue between the front and the back.
module rcw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcw_pkg::span_t push_data,
  output logic           full,
  input  logic           pop,
  output rcw_pkg::span_t head,
  output logic           empty
);
  import rcw_pkg::*;

  span_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

// File: design/rcw_back.sv
// Back: walks each queued run one cache line per cycle into the output register, while that register is not stalled.
module rcw_back #(
  parameter int LINE_BYTES = rcw_pkg::LINE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  rcw_pkg::span_t head,
  input  logic           empty,
  output logic           pop,
  output logic           line_valid,
  input  logic           line_stall,
  output rcw_pkg::line_t line_data
);
  import rcw_pkg::*;

  localparam int LB_BITS = $clog2(LINE_BYTES);

  logic             busy;
  logic [31:0]      cur_addr;
  logic [CNT_W-1:0] rem;
  logic             cur_op;
  logic             out_free;
  logic             step;

  assign out_free = !line_valid || !line_stall;
  assign step     = busy && out_free;
  assign pop      = !busy && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      line_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (step && rem == '0) begin
        busy <= 1'b0;
      end
      if (step) begin
        line_valid <= 1'b1;
      end else if (!line_stall) begin
        line_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr <= head.start_address;
      rem      <= head.cnt_m1;
      cur_op   <= head.op;
    end else if (step) begin
      cur_addr <= cur_addr + 32'(LINE_BYTES);
      rem      <= rem - 1'b1;
    end
    if (step) begin
      line_data.line_address <= cur_addr;
      line_data.line_op      <= cur_op;
      line_data.row_done     <= (rem == '0);
    end
  end

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    line_valid |-> line_data.line_address[LB_BITS-1:0] == '0)
    else $error("line address not aligned");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (step && rem == '0) |=> !busy)
    else $error("walker still busy after last line of run");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (step && rem != '0) |=> busy && cur_addr == $past(cur_addr) + 32'(LINE_BYTES))
    else $error("walker did not advance by one line");

endmodule

// File: design/rect_cache_line_walker.sv
// Rectangular area cache line walker: row items in, cache line beats out.
// Usage:
//   row channel (row_valid/row_stall/row_data): one beat per row of the area.
//     first_row restarts at start_address; other rows step by row_stride.
//   line channel (line_valid/line_stall/line_data): one beat per cache line
//     to clean or invalidate, ascending; row_done marks a row's last line.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): cache_enabled, always ready;
//     write it only while the block is idle.
// Flow: a row is taken in one cycle and classified in the next, so the
//   front takes no new row until it has classified the last one and queued
//   any run it needs. Within a run the back emits one line per cycle while
//   the output is not stalled, and it loads each run from the queue before
//   walking it. A row passes the front register, the run queue, the back's
//   run registers and the output register before its first line beat shows.
// Reset: row address, last-line tracking and cache_enabled clear; queue and
//   output register empty. A stalled line beat holds; the back then stops,
//   the queue fills and row_stall rises until space frees up.
module rect_cache_line_walker #(
  parameter int LINE_BYTES    = rcw_pkg::LINE_BYTES_DEF,
  parameter int MAX_ROW_BYTES = rcw_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           row_valid,
  output logic           row_stall,
  input  rcw_pkg::row_t  row_data,
  output logic           line_valid,
  input  logic           line_stall,
  output rcw_pkg::line_t line_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);
  import rcw_pkg::*;

  logic  cache_enabled;
  logic  push;
  logic  full;
  logic  pop;
  logic  empty;
  span_t push_data;
  span_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cache_enabled <= cfg_data;
    end
  end

  rcw_front #(
    .LINE_BYTES    (LINE_BYTES),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .row_valid     (row_valid),
    .row_stall     (row_stall),
    .row_data      (row_data),
    .cache_enabled (cache_enabled),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  rcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  rcw_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line_data  (line_data)
  );

endmodule

// File: bench/rect_cache_line_walker_tb.sv
// Self-checking testbench for the rectangular area cache line walker.
`timescale 1ns / 100ps

module rect_cache_line_walker_tb;
  import rcw_pkg::*;

  localparam int LINE_SH     = $clog2(LINE_BYTES_DEF);
  localparam int IDX_W       = 32 - LINE_SH;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 200;

  logic  clk;
  logic  rst;
  logic  row_valid;
  logic  row_stall;
  row_t  row_data;
  logic  line_valid;
  logic  line_stall;
  line_t line_data;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_data;

  // Shadow state of the walker
  logic [31:0]      cur_row_addr;
  logic [IDX_W-1:0] track_idx;
  logic             track_valid;
  logic             cache_on;

  line_t pending_lines[$];
  int    mismatches;
  int    rows_sent;
  int    lines_seen;
  bit    calm;
  bit    hold_req;
  int    hold_left;

  rect_cache_line_walker dut (
    .clk       (clk),
    .rst       (rst),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row_data  (row_data),
    .line_valid(line_valid),
    .line_stall(line_stall),
    .line_data (line_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Work out the cache lines one accepted row touches and queue them.
  function automatic void walk_row(row_t r);
    logic [31:0] addr;
    logic [32:0] end_sum;
    logic [63:0] fidx;
    logic [63:0] lidx;
    logic [63:0] cnt;
    logic [63:0] idx;
    logic [10:0] nb;
    line_t       ln;
    if (r.first_row) begin
      addr = r.start_address;
      track_valid = 1'b0;
    end else begin
      addr = cur_row_addr + {16'b0, r.row_stride};
    end
    cur_row_addr = addr;
    nb = (r.row_bytes > MAX_ROW_BYTES_DEF) ? 11'(MAX_ROW_BYTES_DEF) : r.row_bytes;
    if (nb == 0) return;
    fidx = 64'(addr) >> LINE_SH;
    end_sum = {1'b0, addr} + 33'(nb) - 33'd1;
    lidx = 64'(end_sum) >> LINE_SH;
    // skip a first line already handled by the previous row
    if (track_valid && fidx[IDX_W-1:0] == track_idx) fidx = fidx + 64'd1;
    track_idx = lidx[IDX_W-1:0];
    track_valid = 1'b1;
    if (!cache_on || fidx > lidx) return;
    cnt = lidx - fidx + 64'd1;
    if (cnt > 64'(MAX_LINES)) cnt = 64'(MAX_LINES);
    for (int k = 0; k < cnt; k++) begin
      idx = fidx + 64'(k);
      ln.line_address = 32'(idx << LINE_SH);
      ln.line_op      = r.op;
      ln.row_done     = (64'(k) + 64'd1 == cnt);
      pending_lines.push_back(ln);
    end
  endfunction

  // Compare every accepted line beat against the oldest queued line.
  initial begin
    line_t want;
    mismatches = 0;
    lines_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && line_valid && !line_stall) begin
        lines_seen++;
        if (pending_lines.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected line beat, expected none, actual addr %h op %b done %b",
                   $time, line_data.line_address, line_data.line_op, line_data.row_done);
        end else begin
          want = pending_lines.pop_front();
          if (line_data.line_address !== want.line_address) begin
            mismatches++;
            $display("%0t: line_address expected %h actual %h", $time,
                     want.line_address, line_data.line_address);
          end
          if (line_data.line_op !== want.line_op) begin
            mismatches++;
            $display("%0t: line_op expected %b actual %b (addr %h)", $time,
                     want.line_op, line_data.line_op, want.line_address);
          end
          if (line_data.row_done !== want.row_done) begin
            mismatches++;
            $display("%0t: row_done expected %b actual %b (addr %h)", $time,
                     want.row_done, line_data.row_done, want.line_address);
          end
        end
      end
    end
  end

  // Line side stall: random, off in calm stretches, forced on for a hold-off.
  initial begin
    line_stall = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        line_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        line_stall <= 1'b0;
      end else begin
        line_stall <= ($urandom_range(99) < 30);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("rect_cache_line_walker_tb failed");
    $finish;
  end

  task automatic send_row(row_t r);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 30) begin
      row_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    row_valid <= 1'b1;
    row_data  <= r;
    @(posedge clk);
    while (row_stall) @(posedge clk);
    walk_row(r);
    rows_sent++;
  endtask

  function automatic row_t mk_row(logic op, logic first, logic [31:0] start,
                                  logic [10:0] nbytes, logic [15:0] stride);
    row_t r;
    r.op            = op;
    r.first_row     = first;
    r.start_address = start;
    r.row_bytes     = nbytes;
    r.row_stride    = stride;
    return r;
  endfunction

  // Drop valid, let every queued line drain, then let the pipeline empty.
  task automatic wait_idle();
    @(negedge clk);
    row_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_cache(logic enable);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= enable;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cache_on = enable;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [10:0] pick_bytes();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 11'd0;
    if (roll < 20) return 11'($urandom_range(1025, 2047));
    if (roll < 35) return 11'($urandom_range(1, 32));
    return 11'($urandom_range(1, 1024));
  endfunction

  task automatic test_row_after_reset();
    set_cache(1'b1);
    // no area started yet: row address is the stride, nothing to skip
    send_row(mk_row(1'b0, 1'b0, 32'h0, 11'd64, 16'd100));
    send_row(mk_row(1'b0, 1'b0, 32'h0, 11'd64, 16'd64));
  endtask

  task automatic test_field_extremes();
    send_row(mk_row(1'b1, 1'b1, 32'hFFFF_FFF0, 11'd64, 16'd0));
    // wrapped row lies in the line left by the row across the top
    send_row(mk_row(1'b1, 1'b0, 32'h0, 11'd16, 16'd48));
    send_row(mk_row(1'b0, 1'b1, 32'h0, 11'd0, 16'hFFFF));
    send_row(mk_row(1'b0, 1'b0, 32'hFFFF_FFFF, 11'd1, 16'd0));
    send_row(mk_row(1'b1, 1'b1, 32'hFFFF_FFFF, 11'd2047, 16'd0));
    send_row(mk_row(1'b0, 1'b0, 32'h0, 11'd1024, 16'hFFFF));
    send_row(mk_row(1'b0, 1'b1, 32'h1234_5678, 11'd1, 16'd0));
    send_row(mk_row(1'b1, 1'b1, 32'h8000_0000, 11'd1024, 16'hFFFF));
    send_row(mk_row(1'b1, 1'b0, 32'hFFFF_FFFF, 11'd1025, 16'd1));
  endtask

  task automatic test_shared_line();
    send_row(mk_row(1'b0, 1'b1, 32'h0000_1000, 11'd40, 16'd0));
    send_row(mk_row(1'b0, 1'b0, 32'h0, 11'd8, 16'd48));
    // zero-byte row keeps the tracked line
    send_row(mk_row(1'b0, 1'b0, 32'h0, 11'd0, 16'd0));
    send_row(mk_row(1'b0, 1'b0, 32'h0, 11'd4, 16'd0));
    send_row(mk_row(1'b1, 1'b0, 32'h0, 11'd96, 16'd4));
  endtask

  task automatic test_cache_disabled();
    wait_idle();
    set_cache(1'b0);
    send_row(mk_row(1'b1, 1'b1, 32'h0000_2000, 11'd64, 16'd0));
    send_row(mk_row(1'b0, 1'b0, 32'h0, 11'd64, 16'd32));
    wait_idle();
    set_cache(1'b1);
    // tracking advanced while disabled, so this row skips its first line
    send_row(mk_row(1'b1, 1'b0, 32'h0, 11'd64, 16'd32));
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = 1'b1;
    send_row(mk_row(1'b0, 1'b1, 32'h4000_0000, 11'd1024, 16'd0));
    repeat (11) send_row(mk_row(1'($urandom_range(1)), 1'b0, 32'h0, 11'd1024, 16'd1024));
    // sender pauses until the backlog is gone
    wait_idle();
    repeat (3) send_row(mk_row(1'b1, 1'b0, 32'h0, 11'd200, 16'd1000));
  endtask

  task automatic test_random_areas(int n_items);
    row_t        r;
    int          sent;
    int          rows_left;
    logic        op_area;
    logic [10:0] bytes_area;
    sent = 0;
    while (sent < n_items) begin
      calm = (sent >= 60 && sent < 100);
      if ($urandom_range(99) < 15) begin
        r = mk_row(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                   11'($urandom_range(0, 2047)), 16'($urandom_range(0, 65535)));
        send_row(r);
        sent++;
      end else begin
        op_area    = 1'($urandom_range(1));
        rows_left  = $urandom_range(1, 8);
        bytes_area = pick_bytes();
        r = mk_row(op_area, 1'b1,
                   ($urandom_range(3) == 0) ? (32'hFFFF_F000 | $urandom_range(4095)) : $urandom,
                   bytes_area, 16'($urandom_range(0, 65535)));
        send_row(r);
        sent++;
        repeat (rows_left) begin
          r.first_row     = 1'b0;
          r.op            = ($urandom_range(9) == 0) ? ~op_area : op_area;
          r.start_address = $urandom;
          r.row_bytes     = ($urandom_range(4) == 0) ? pick_bytes() : bytes_area;
          case ($urandom_range(3))
            0: r.row_stride = 16'(bytes_area);
            1: r.row_stride = 16'($urandom_range(0, 1100));
            2: r.row_stride = 16'($urandom_range(0, 65535));
            default: r.row_stride = 16'(bytes_area) + 16'($urandom_range(0, 64));
          endcase
          send_row(r);
          sent++;
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    row_valid    = 1'b0;
    row_data     = '0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    rows_sent    = 0;
    cur_row_addr = '0;
    track_idx    = '0;
    track_valid  = 1'b0;
    cache_on     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_row_after_reset();
    test_field_extremes();
    test_shared_line();
    test_cache_disabled();
    test_backpressure();
    test_random_areas(146);

    wait_idle();
    $display("Covered %0d rows and %0d line beats: clean and invalidate, top-of-memory wrap,",
             rows_sent, lines_seen);
    $display("shared and zero-byte rows, oversized rows, cache off and a long line stall.");
    if (mismatches == 0) begin
      $display("rect_cache_line_walker_tb passed");
    end else begin
      $display("rect_cache_line_walker_tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rcw_pkg.sv
design/rcw_front.sv
design/rcw_queue.sv
design/rcw_back.sv
design/rect_cache_line_walker.sv
bench/rect_cache_line_walker_tb.sv
